/* hw/rtl/prt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the port reply tracker.
// No dependencies; used by every module of the block.
package prt_pkg;

    // Table geometry
    localparam int PORT_COUNT = 65536;
    localparam int PORT_AW    = $clog2(PORT_COUNT);
    localparam logic [PORT_AW-1:0] PORT_LAST = PORT_AW'(PORT_COUNT - 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Frame parsing
    localparam logic [15:0] ETH_V4    = 16'h0800;
    localparam logic [15:0] ETH_V6    = 16'h86DD;
    localparam logic [6:0]  TCP_AT_V4 = 7'd34;
    localparam logic [6:0]  TCP_AT_V6 = 7'd54;
    localparam logic [6:0]  ETH_HI_AT = 7'd12;
    localparam logic [6:0]  ETH_LO_AT = 7'd13;
    localparam logic [6:0]  HDR_END   = 7'd14;
    localparam logic [6:0]  FLAGS_OFS = 7'd13;
    localparam logic [6:0]  POS_MAX   = 7'd127;
    localparam int          FLAG_ACK_BIT = 4;
    localparam int          FLAG_RST_BIT = 2;

    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_MARK  = 2'd1,
        FN_BYTE  = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_UNSCANNED = 2'd0,
        ST_SCANNED   = 2'd1,
        ST_OPEN      = 2'd2,
        ST_CLOSED    = 2'd3
    } t_state;

    typedef enum logic [2:0] {
        OUT_OPENED   = 3'd0,
        OUT_CLOSED   = 3'd1,
        OUT_NOCHANGE = 3'd2,
        OUT_FLAGS    = 3'd3,
        OUT_UNKNOWN  = 3'd4,
        OUT_SHORT    = 3'd5
    } t_outcome;

    typedef enum logic {
        RULE_SYNACK = 1'b0,
        RULE_RESET  = 1'b1
    } t_rule;

    typedef enum logic {
        RK_FRAME = 1'b0,
        RK_READ  = 1'b1
    } t_rkind;

    typedef enum logic [1:0] {
        RM_ALL        = 2'd0,
        RM_OPEN       = 2'd1,
        RM_CLOSED     = 2'd2,
        RM_NOT_CLOSED = 2'd3
    } t_rmode;

    // One classified item handed from front to back.
    // For FN_BYTE the entry is a finished frame; pre holds an early verdict.
    typedef struct packed {
        t_func       op;
        logic [15:0] port;
        t_rule       rule;
        t_outcome    pre;
    } t_cmd;

    function automatic logic port_in_range(input logic [15:0] port);
        port_in_range = ({1'b0, port} < 17'(PORT_COUNT));
    endfunction

    function automatic logic state_shown(input t_rmode mode, input t_state st);
        case (mode)
            RM_ALL:    state_shown = (st != ST_UNSCANNED);
            RM_OPEN:   state_shown = (st == ST_OPEN);
            RM_CLOSED: state_shown = (st == ST_CLOSED);
            default:   state_shown = (st == ST_SCANNED) || (st == ST_OPEN);
        endcase
    endfunction

endpackage

/* hw/rtl/prt_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front parser and the back table engine.
// Depends on prt_pkg for the entry type and depth.
module prt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prt_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output prt_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import prt_pkg::*;

    t_cmd                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue popped while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

/* hw/rtl/prt_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input beats, parses frame headers and classifies items.
// Depends on prt_pkg; feeds prt_queue.
module prt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  prt_pkg::t_func i_func,
    input  logic [15:0]   i_port_number,
    input  logic [7:0]    i_frame_byte,
    input  logic          i_frame_last,
    input  prt_pkg::t_rule i_capture_kind,
    input  logic          i_queue_full,
    input  logic          i_init_busy,
    output logic          o_ready,
    output logic          o_push,
    output prt_pkg::t_cmd o_cmd
);
    import prt_pkg::*;

    logic [6:0]  r_pos;
    logic [15:0] r_ether;
    logic [15:0] r_sport;
    logic [7:0]  r_flags;
    logic        r_flags_seen;

    logic [6:0]  n_pos;
    logic [15:0] n_ether;
    logic [15:0] n_sport;
    logic [7:0]  n_flags;
    logic        n_flags_seen;
    logic        w_known;
    logic [6:0]  w_base;
    logic        w_accept;
    logic        w_byte;

    assign o_ready  = !i_queue_full && !i_init_busy;
    assign w_accept = i_valid && o_ready;
    assign w_byte   = (i_func == FN_BYTE);
    assign o_push   = w_accept && (!w_byte || i_frame_last);

    always_comb begin
        n_ether      = r_ether;
        n_sport      = r_sport;
        n_flags      = r_flags;
        n_flags_seen = r_flags_seen;
        if (r_pos == ETH_HI_AT) begin
            n_ether[15:8] = i_frame_byte;
        end else if (r_pos == ETH_LO_AT) begin
            n_ether[7:0] = i_frame_byte;
        end
        w_known = (r_pos >= HDR_END) && ((r_ether == ETH_V4) || (r_ether == ETH_V6));
        w_base  = (r_ether == ETH_V4) ? TCP_AT_V4 : TCP_AT_V6;
        if (w_known) begin
            if (r_pos == w_base) begin
                n_sport[15:8] = i_frame_byte;
            end else if (r_pos == w_base + 7'd1) begin
                n_sport[7:0] = i_frame_byte;
            end else if (r_pos == w_base + FLAGS_OFS) begin
                n_flags      = i_frame_byte;
                n_flags_seen = 1'b1;
            end
        end
        n_pos = (r_pos != POS_MAX) ? r_pos + 7'd1 : r_pos;
    end

    // Classify the item; a frame entry carries its early verdict
    always_comb begin
        o_cmd.op   = i_func;
        o_cmd.port = i_port_number;
        o_cmd.rule = i_capture_kind;
        o_cmd.pre  = OUT_NOCHANGE;
        if (w_byte) begin
            o_cmd.port = '0;
            if (n_pos < HDR_END) begin
                o_cmd.pre = OUT_SHORT;
            end else if ((n_ether != ETH_V4) && (n_ether != ETH_V6)) begin
                o_cmd.pre = OUT_UNKNOWN;
            end else if (!n_flags_seen) begin
                o_cmd.pre = OUT_SHORT;
            end else begin
                o_cmd.port = n_sport;
                if ((i_capture_kind == RULE_SYNACK) &&
                    (!n_flags[FLAG_ACK_BIT] || n_flags[FLAG_RST_BIT])) begin
                    o_cmd.pre = OUT_FLAGS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_ether      <= '0;
            r_sport      <= '0;
            r_flags      <= '0;
            r_flags_seen <= 1'b0;
        end else if (w_accept && w_byte) begin
            if (i_frame_last) begin
                r_pos        <= '0;
                r_ether      <= '0;
                r_sport      <= '0;
                r_flags      <= '0;
                r_flags_seen <= 1'b0;
            end else begin
                r_pos        <= n_pos;
                r_ether      <= n_ether;
                r_sport      <= n_sport;
                r_flags      <= n_flags;
                r_flags_seen <= n_flags_seen;
            end
        end
    end

endmodule

/* hw/rtl/prt_back.sv */
`timescale 1ns / 1ps
// Back end: owns the per-port reply table, runs queued commands and
// holds the result register. Depends on prt_pkg.
module prt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [1:0]     i_cfg_wr_data,
    input  logic           i_cmd_valid,
    input  prt_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_init_busy,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output prt_pkg::t_rkind o_kind,
    output logic [15:0]    o_reply_port,
    output prt_pkg::t_outcome o_outcome,
    output prt_pkg::t_state o_port_state,
    output logic           o_shown
);
    import prt_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_EXEC
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [PORT_AW-1:0] r_cnt, n_cnt;
    t_cmd               r_cmd, n_cmd;
    t_rmode             r_mode;
    logic               r_out_valid, n_out_valid;
    t_rkind             r_out_kind, n_out_kind;
    logic [15:0]        r_out_port, n_out_port;
    t_outcome           r_out_outcome, n_out_outcome;
    t_state             r_out_state, n_out_state;
    logic               r_out_shown, n_out_shown;

    logic [1:0]         r_mem [PORT_COUNT];
    logic [1:0]         r_rd;
    logic               w_we;
    logic [PORT_AW-1:0] w_waddr;
    t_state             w_wdata;
    logic               w_re;
    logic [PORT_AW-1:0] w_raddr;
    logic               w_out_free;
    t_state             w_st;

    assign o_init_busy  = (r_state == S_INIT);
    assign o_m_tvalid   = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_reply_port = r_out_port;
    assign o_outcome    = r_out_outcome;
    assign o_port_state = r_out_state;
    assign o_shown      = r_out_shown;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RM_ALL;
        end else if (i_cfg_wr_en) begin
            r_mode <= t_rmode'(i_cfg_wr_data);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_cmd         = r_cmd;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_port    = r_out_port;
        n_out_outcome = r_out_outcome;
        n_out_state   = r_out_state;
        n_out_shown   = r_out_shown;
        o_pop         = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_cnt;
        w_wdata       = ST_UNSCANNED;
        w_re          = 1'b0;
        w_raddr       = i_cmd.port[PORT_AW-1:0];
        w_out_free    = !r_out_valid || i_m_tready;
        w_st          = port_in_range(r_cmd.port) ? t_state'(r_rd) : ST_UNSCANNED;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT, S_CLEAR: begin
                // sweep the table back to unscanned, one entry a cycle
                w_we = 1'b1;
                if (r_cnt == PORT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        FN_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        FN_MARK: begin
                            w_we    = port_in_range(i_cmd.port);
                            w_waddr = i_cmd.port[PORT_AW-1:0];
                            w_wdata = ST_SCANNED;
                        end
                        default: begin
                            w_re    = 1'b1;
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    w_waddr     = r_cmd.port[PORT_AW-1:0];
                    if (r_cmd.op == FN_READ) begin
                        n_out_kind    = RK_READ;
                        n_out_port    = r_cmd.port;
                        n_out_outcome = OUT_NOCHANGE;
                        n_out_state   = w_st;
                        n_out_shown   = state_shown(r_mode, w_st);
                    end else begin
                        n_out_kind  = RK_FRAME;
                        n_out_shown = 1'b0;
                        n_out_port  = r_cmd.port;
                        n_out_state = w_st;
                        if ((r_cmd.pre == OUT_SHORT) || (r_cmd.pre == OUT_UNKNOWN)) begin
                            n_out_outcome = r_cmd.pre;
                            n_out_port    = '0;
                            n_out_state   = ST_UNSCANNED;
                        end else if (r_cmd.rule == RULE_SYNACK) begin
                            if (r_cmd.pre == OUT_FLAGS) begin
                                n_out_outcome = OUT_FLAGS;
                            end else if (w_st != ST_UNSCANNED) begin
                                w_we          = 1'b1;
                                w_wdata       = ST_OPEN;
                                n_out_outcome = OUT_OPENED;
                                n_out_state   = ST_OPEN;
                            end else begin
                                n_out_outcome = OUT_NOCHANGE;
                            end
                        end else begin
                            if ((w_st == ST_SCANNED) || (w_st == ST_CLOSED)) begin
                                w_we          = 1'b1;
                                w_wdata       = ST_CLOSED;
                                n_out_outcome = OUT_CLOSED;
                                n_out_state   = ST_CLOSED;
                            end else begin
                                n_out_outcome = OUT_NOCHANGE;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd         <= n_cmd;
        r_out_kind    <= n_out_kind;
        r_out_port    <= n_out_port;
        r_out_outcome <= n_out_outcome;
        r_out_state   <= n_out_state;
        r_out_shown   <= n_out_shown;
    end

    a_frame_not_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == RK_FRAME)) |-> !r_out_shown)
        else $error("frame result flagged as shown");

    a_read_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == RK_READ)) |-> (r_out_outcome == OUT_NOCHANGE))
        else $error("read result with a frame outcome");

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INIT) || (r_state == S_CLEAR)) |-> !o_pop)
        else $error("command taken during a table sweep");

endmodule

/* hw/rtl/port_reply_tracker_unit.sv */
`timescale 1ns / 1ps
// Top level of the port reply tracker: stream ports, front parser,
// command queue and table engine. Depends on prt_pkg, prt_front, prt_queue, prt_back.

// After reset the block sweeps its 65536-entry reply table to unscanned, one entry a
// cycle, and holds o_s_tready low until the sweep is done. Frame bytes that are not the
// last of a frame are taken one per cycle by the front parser while o_s_tready is high.
// A frame's last byte or a read takes the table engine through a memory read, then the
// update and result; a mark is written when taken and a clear walks the table, while a
// four-entry queue keeps the parser taking beats. Results wait in an output register, so
// a stalled master side only stops input once the queue fills. The user must write the
// report mode via i_cfg_wr_en only while the block is idle; the block does not enforce it.
module port_reply_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,  // report_mode
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,      // [15:0] port_number, [23:16] frame_byte
    input  logic [2:0]  i_s_tuser,      // [1:0] func, [2] capture_kind
    input  logic        i_s_tlast,      // frame_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,      // [15:0] reply_port, [18:16] outcome,
                                        // [20:19] port_state, [21] shown, [23:22] zero
    output logic [0:0]  o_m_tuser       // [0] result_kind
);
    import prt_pkg::*;

    t_cmd     w_push_cmd;
    t_cmd     w_head;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    logic     w_init_busy;
    t_rkind   w_kind;
    logic [15:0] w_port;
    t_outcome w_outcome;
    t_state   w_state;
    logic     w_shown;

    prt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .i_func         (t_func'(i_s_tuser[1:0])),
        .i_port_number  (i_s_tdata[15:0]),
        .i_frame_byte   (i_s_tdata[23:16]),
        .i_frame_last   (i_s_tlast),
        .i_capture_kind (t_rule'(i_s_tuser[2])),
        .i_queue_full   (w_full),
        .i_init_busy    (w_init_busy),
        .o_ready        (o_s_tready),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    prt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    prt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (!w_empty),
        .i_cmd         (w_head),
        .o_pop         (w_pop),
        .o_init_busy   (w_init_busy),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_kind        (w_kind),
        .o_reply_port  (w_port),
        .o_outcome     (w_outcome),
        .o_port_state  (w_state),
        .o_shown       (w_shown)
    );

    assign o_m_tdata = {2'b00, w_shown, w_state, w_outcome, w_port};
    assign o_m_tuser = w_kind;

endmodule

/* tb/sv/tb_port_reply_tracker_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for port_reply_tracker_unit: directed and random command and
// frame traffic with a beat-level predictor of the reply table. Depends on prt_pkg.
module tb_port_reply_tracker_unit;
    import prt_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef logic [7:0] t_frame[$];

    typedef struct {
        t_rkind      kind;
        logic [15:0] port;
        t_outcome    outc;
        t_state      st;
        logic        shown;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_wr_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;     // [15:0] port_number, [23:16] frame_byte
    logic [2:0]  i_s_tuser;     // [1:0] func, [2] capture_kind
    logic        i_s_tlast;     // frame_last
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;     // [15:0] reply_port, [18:16] outcome, [20:19] port_state,
                                // [21] shown, [23:22] zero
    logic [0:0]  o_m_tuser;     // [0] result_kind

    // Predicted block state
    t_state      port_table [PORT_COUNT];
    t_rmode      report_mode_now = RM_ALL;
    logic [6:0]  parse_pos   = '0;
    logic [15:0] parse_eth   = '0;
    logic [15:0] parse_sport = '0;
    logic [7:0]  parse_flags = '0;
    logic        flags_caught = 1'b0;

    t_reply      expected_replies[$];
    bit          idle_bursts = 1'b0;
    bit          tail_silent = 1'b0;
    int          error_count = 0;
    int          beats_sent = 0;
    int          frames_sent = 0;
    int          clears_sent = 0;
    int          replies_due = 0;
    int          replies_checked = 0;
    int          clears_left = 2;
    int unsigned cycles = 0;

    port_reply_tracker_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d replies outstanding",
                 cycles, expected_replies.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Master side: random stall bursts while idle_bursts is set
    initial begin : reply_sink
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_bursts && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    function automatic logic listed(input t_rmode m, input t_state s);
        case (m)
            RM_ALL:    return s != ST_UNSCANNED;
            RM_OPEN:   return s == ST_OPEN;
            RM_CLOSED: return s == ST_CLOSED;
            default:   return s == ST_SCANNED || s == ST_OPEN;
        endcase
    endfunction

    function automatic void log_mismatch(input string what, input t_reply want,
                                         input t_reply got);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s: expected kind %0d port %h outcome %0d state %0d shown %0d,"
                     , $time, what, want.kind, want.port, want.outc, want.st, want.shown,
                     " got kind %0d port %h outcome %0d state %0d shown %0d",
                     got.kind, got.port, got.outc, got.st, got.shown);
    endfunction

    always @(posedge i_clk) begin : check_replies
        t_reply got;
        t_reply want;
        if (o_m_tvalid && i_m_tready) begin
            got.kind  = t_rkind'(o_m_tuser[0]);
            got.port  = o_m_tdata[15:0];
            got.outc  = t_outcome'(o_m_tdata[18:16]);
            got.st    = t_state'(o_m_tdata[20:19]);
            got.shown = o_m_tdata[21];
            replies_checked++;
            if (expected_replies.size() == 0) begin
                log_mismatch("unexpected reply", got, got);
            end else begin
                want = expected_replies.pop_front();
                if (got.kind !== want.kind || got.port !== want.port ||
                    got.outc !== want.outc || got.st !== want.st ||
                    got.shown !== want.shown)
                    log_mismatch("reply mismatch", want, got);
            end
        end
    end

    function automatic void push_reply(input t_reply r);
        expected_replies.push_back(r);
        replies_due++;
        tail_silent = 1'b0;
    endfunction

    // Advance the predicted table and parser by one accepted beat
    function automatic void predict_reply(input t_func f, input logic [15:0] port,
                                          input logic [7:0] fbyte, input logic is_last,
                                          input t_rule capture);
        t_reply     r;
        logic [6:0] hdr;
        logic       known;
        tail_silent = 1'b1;
        case (f)
            FN_CLEAR: begin
                foreach (port_table[i]) port_table[i] = ST_UNSCANNED;
                clears_sent++;
            end
            FN_MARK: port_table[port] = ST_SCANNED;
            FN_READ: begin
                r.kind  = RK_READ;
                r.port  = port;
                r.outc  = OUT_NOCHANGE;
                r.st    = port_table[port];
                r.shown = listed(report_mode_now, r.st);
                push_reply(r);
            end
            default: begin
                if (parse_pos == ETH_HI_AT) parse_eth[15:8] = fbyte;
                else if (parse_pos == ETH_LO_AT) parse_eth[7:0] = fbyte;
                known = 1'b0;
                hdr   = '0;
                if (parse_pos >= HDR_END) begin
                    if (parse_eth == ETH_V4) begin
                        hdr = TCP_AT_V4;
                        known = 1'b1;
                    end else if (parse_eth == ETH_V6) begin
                        hdr = TCP_AT_V6;
                        known = 1'b1;
                    end
                end
                if (known) begin
                    if (parse_pos == hdr) parse_sport[15:8] = fbyte;
                    else if (parse_pos == hdr + 7'd1) parse_sport[7:0] = fbyte;
                    else if (parse_pos == hdr + FLAGS_OFS) begin
                        parse_flags  = fbyte;
                        flags_caught = 1'b1;
                    end
                end
                if (parse_pos != POS_MAX) parse_pos++;
                if (is_last) begin
                    r.kind  = RK_FRAME;
                    r.port  = '0;
                    r.st    = ST_UNSCANNED;
                    r.shown = 1'b0;
                    if (parse_pos < HDR_END) r.outc = OUT_SHORT;
                    else if (parse_eth != ETH_V4 && parse_eth != ETH_V6) r.outc = OUT_UNKNOWN;
                    else if (!flags_caught) r.outc = OUT_SHORT;
                    else begin
                        r.port = parse_sport;
                        r.st   = port_table[parse_sport];
                        if (capture == RULE_SYNACK) begin
                            if (!parse_flags[FLAG_ACK_BIT] || parse_flags[FLAG_RST_BIT]) begin
                                r.outc = OUT_FLAGS;
                            end else if (r.st != ST_UNSCANNED) begin
                                r.st   = ST_OPEN;
                                r.outc = OUT_OPENED;
                            end else begin
                                r.outc = OUT_NOCHANGE;
                            end
                        end else if (r.st == ST_SCANNED || r.st == ST_CLOSED) begin
                            r.st   = ST_CLOSED;
                            r.outc = OUT_CLOSED;
                        end else begin
                            r.outc = OUT_NOCHANGE;
                        end
                        port_table[parse_sport] = r.st;
                    end
                    push_reply(r);
                    frames_sent++;
                    parse_pos    = '0;
                    parse_eth    = '0;
                    parse_sport  = '0;
                    parse_flags  = '0;
                    flags_caught = 1'b0;
                end
            end
        endcase
    endfunction

    task automatic send_beat(input t_func f, input logic [15:0] port, input logic [7:0] fbyte,
                             input logic is_last, input t_rule capture);
        if (idle_bursts && $urandom_range(0, 9) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {fbyte, port};
        i_s_tuser  <= {capture, f};
        i_s_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        beats_sent++;
        predict_reply(f, port, fbyte, is_last, capture);
    endtask

    // Unused fields of a command beat carry random values
    task automatic send_cmd(input t_func f, input logic [15:0] port);
        send_beat(f, port, 8'($urandom), 1'($urandom), t_rule'($urandom_range(0, 1)));
    endtask

    task automatic send_bytes(ref t_frame fb, input int lo, input int hi, input t_rule capture);
        for (int i = lo; i <= hi; i++) begin
            if (i == fb.size() - 1)
                send_beat(FN_BYTE, 16'($urandom), fb[i], 1'b1, capture);
            else
                send_beat(FN_BYTE, 16'($urandom), fb[i], 1'b0,
                          t_rule'($urandom_range(0, 1)));
        end
    endtask

    function automatic void build_frame(ref t_frame fb, input logic [15:0] eth,
                                        input logic [15:0] sport, input logic [7:0] flags,
                                        input int len);
        int base;
        base = (eth == ETH_V6) ? int'(TCP_AT_V6) : int'(TCP_AT_V4);
        fb.delete();
        repeat (len) fb.push_back(8'($urandom));
        if (len > 12) fb[12] = eth[15:8];
        if (len > 13) fb[13] = eth[7:0];
        if (len > base) fb[base] = sport[15:8];
        if (len > base + 1) fb[base + 1] = sport[7:0];
        if (len > base + 13) fb[base + 13] = flags;
    endfunction

    task automatic send_frame(input logic [15:0] eth, input logic [15:0] sport,
                              input logic [7:0] flags, input int len, input t_rule capture);
        t_frame fb;
        build_frame(fb, eth, sport, flags, len);
        send_bytes(fb, 0, len - 1, capture);
    endtask

    // Drop valid and wait until every predicted reply has been seen
    task automatic hold_until_replied();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_replies.size() != 0);
    endtask

    // A trailing read proves that any clear or mark ahead of it has finished
    task automatic settle();
        if (tail_silent) send_cmd(FN_READ, 16'($urandom));
        hold_until_replied();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_report_mode(input t_rmode m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        report_mode_now = m;
    endtask

    function automatic logic [15:0] pick_port();
        logic [15:0] pool [6] = '{16'h0050, 16'h01BB, 16'h8000, 16'h7FFF, 16'h1F90, 16'h0016};
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            9:       return 16'($urandom);
            default: return pool[$urandom_range(0, 5)];
        endcase
    endfunction

    task automatic random_frame();
        t_frame      fb;
        logic [15:0] eth;
        logic [15:0] sport;
        logic [7:0]  flags;
        int          len;
        int          base;
        int          pick;
        int          cut;
        t_rule       capture;
        eth  = ($urandom_range(0, 2) == 0) ? ETH_V6 : ETH_V4;
        base = (eth == ETH_V6) ? int'(TCP_AT_V6) : int'(TCP_AT_V4);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            len = base + 14 + $urandom_range(0, 8);
        end else if (pick < 85) begin
            len = $urandom_range(128, 150);
        end else if (pick < 91) begin
            len = $urandom_range(14, base + 13);
        end else if (pick < 96) begin
            eth = 16'($urandom);
            if (eth == ETH_V4 || eth == ETH_V6) eth[0] = ~eth[0];
            len = $urandom_range(14, 60);
        end else begin
            len = $urandom_range(1, 13);
        end
        if ($urandom_range(0, 9) < 7)
            flags = (8'($urandom) & ~8'h04) | 8'h10;
        else
            flags = 8'($urandom);
        sport   = pick_port();
        capture = t_rule'($urandom_range(0, 1));
        build_frame(fb, eth, sport, flags, len);
        if ($urandom_range(0, 7) == 0) begin
            // slip a command into the middle of the frame
            cut = $urandom_range(1, len - 1);
            send_bytes(fb, 0, cut - 1, capture);
            send_cmd(($urandom_range(0, 1) != 0) ? FN_READ : FN_MARK, pick_port());
            send_bytes(fb, cut, len - 1, capture);
        end else begin
            send_bytes(fb, 0, len - 1, capture);
        end
    endtask

    task automatic test_commands();
        send_cmd(FN_READ, 16'h0000);
        send_cmd(FN_MARK, 16'h0000);
        send_cmd(FN_MARK, 16'hFFFF);
        send_cmd(FN_MARK, 16'h1234);
        send_cmd(FN_READ, 16'h0000);
        send_cmd(FN_READ, 16'hFFFF);
        send_cmd(FN_READ, 16'h1234);
        send_cmd(FN_READ, 16'h5555);
    endtask

    task automatic test_synack_rule();
        send_cmd(FN_MARK, 16'h0050);
        send_frame(ETH_V4, 16'h0050, 8'h12, 48, RULE_SYNACK);
        send_frame(ETH_V4, 16'h0051, 8'h12, 48, RULE_SYNACK);
        send_frame(ETH_V4, 16'h0050, 8'h14, 48, RULE_SYNACK);
        send_frame(ETH_V4, 16'h0050, 8'h02, 48, RULE_SYNACK);
    endtask

    task automatic test_reset_rule();
        send_cmd(FN_MARK, 16'h01BB);
        send_frame(ETH_V4, 16'h01BB, 8'h00, 48, RULE_RESET);
        send_frame(ETH_V4, 16'h01BB, 8'h04, 49, RULE_RESET);
        send_frame(ETH_V4, 16'h0050, 8'h14, 48, RULE_RESET);
        // a closed port still opens on a good SYN-ACK
        send_frame(ETH_V4, 16'h01BB, 8'h12, 48, RULE_SYNACK);
        send_frame(ETH_V6, 16'h0000, 8'h04, 68, RULE_RESET);
    endtask

    task automatic test_malformed_frames();
        send_frame(ETH_V4, 16'h0050, 8'h12, 1, RULE_SYNACK);
        send_frame(ETH_V4, 16'h0050, 8'h12, 13, RULE_SYNACK);
        send_frame(ETH_V4, 16'h0050, 8'h12, 14, RULE_SYNACK);
        send_frame(16'h1234, 16'h0050, 8'h12, 14, RULE_RESET);
        send_frame(ETH_V4, 16'h0050, 8'h12, 47, RULE_SYNACK);
        send_frame(ETH_V6, 16'h0050, 8'h12, 130, RULE_SYNACK);
        send_frame(16'h86DC, 16'h0050, 8'h12, 20, RULE_SYNACK);
        send_frame(16'h0000, 16'h0050, 8'h12, 20, RULE_SYNACK);
        send_frame(16'hFFFF, 16'h0050, 8'h12, 20, RULE_RESET);
    endtask

    // Clear, mark and read in the middle of a frame leave its parse alone
    task automatic test_mid_frame_commands();
        t_frame fb;
        build_frame(fb, ETH_V4, 16'h1F90, 8'h12, 52);
        send_bytes(fb, 0, 19, RULE_SYNACK);
        send_cmd(FN_MARK, 16'h1F90);
        send_cmd(FN_READ, 16'h1F90);
        send_bytes(fb, 20, 35, RULE_SYNACK);
        send_cmd(FN_CLEAR, 16'h1F90);
        send_bytes(fb, 36, 45, RULE_SYNACK);
        send_cmd(FN_MARK, 16'h1F90);
        send_bytes(fb, 46, 51, RULE_SYNACK);
        send_cmd(FN_READ, 16'h1F90);
        send_cmd(FN_READ, 16'h0050);
    endtask

    // Ports left closed, open, scanned and unscanned by the earlier tests
    task automatic test_report_modes();
        t_rmode modes [4] = '{RM_ALL, RM_OPEN, RM_CLOSED, RM_NOT_CLOSED};
        foreach (modes[i]) begin
            settle();
            write_report_mode(modes[i]);
            send_cmd(FN_READ, 16'h0000);
            send_cmd(FN_READ, 16'h0050);
            send_cmd(FN_READ, 16'h1234);
            send_cmd(FN_READ, 16'h5555);
        end
    endtask

    task automatic test_clear();
        send_cmd(FN_MARK, 16'h0000);
        send_cmd(FN_MARK, 16'hFFFF);
        send_cmd(FN_CLEAR, 16'hFFFF);
        send_cmd(FN_READ, 16'h0000);
        send_cmd(FN_READ, 16'hFFFF);
        send_cmd(FN_READ, 16'h0200);
        send_cmd(FN_READ, 16'h0300);
    endtask

    task automatic test_random_traffic(input t_rmode m, input bit bursts, input int beat_goal);
        int b0;
        int pick;
        settle();
        write_report_mode(m);
        idle_bursts = bursts;
        b0 = beats_sent;
        while (beats_sent - b0 < beat_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                random_frame();
            end else if (pick < 65) begin
                send_cmd(FN_READ, pick_port());
            end else if (pick < 90) begin
                send_cmd(FN_MARK, pick_port());
            end else if (pick < 92 && clears_left > 0) begin
                clears_left--;
                send_cmd(FN_CLEAR, pick_port());
            end else if (pick < 95) begin
                hold_until_replied();
            end else begin
                send_cmd(FN_READ, pick_port());
            end
        end
    endtask

    initial begin : main
        foreach (port_table[i]) port_table[i] = ST_UNSCANNED;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        i_s_tuser     <= '0;
        i_s_tlast     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_report_mode(RM_ALL);

        idle_bursts = 1'b1;
        test_commands();
        test_synack_rule();
        test_reset_rule();
        test_malformed_frames();
        test_report_modes();
        test_mid_frame_commands();
        test_clear();

        test_random_traffic(RM_OPEN, 1'b1, 30);
        test_random_traffic(RM_CLOSED, 1'b1, 30);
        test_random_traffic(RM_NOT_CLOSED, 1'b1, 25);
        test_random_traffic(RM_ALL, 1'b0, 25);

        settle();
        repeat (20) @(posedge i_clk);
        if (expected_replies.size() != 0) begin
            error_count++;
            $display("%0d replies never arrived", expected_replies.size());
        end

        $display("Sent %0d beats: %0d frames and %0d table clears; checked %0d replies.",
                 beats_sent, frames_sent, clears_sent, replies_checked);
        $display("Both capture rules, malformed frames and all four report modes exercised.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", error_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/prt_pkg.sv
hw/rtl/prt_queue.sv
hw/rtl/prt_front.sv
hw/rtl/prt_back.sv
hw/rtl/port_reply_tracker_unit.sv
tb/sv/tb_port_reply_tracker_unit.sv
